/* rtl/gfa_pkg.sv */
// Shared types, constants and arithmetic helpers of the Gaussian field accumulator.
// Depends on nothing; every other file of the block refers to it by scoped names.

package gfa_pkg;

    // Geometry and fixed-point constants.
    localparam int DIMENSIONS      = 3;
    localparam int DIM_W           = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int Q_W             = 48;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_VAL_W       = 17;
    localparam int ARG_W           = 20;
    localparam int Y_W             = 21;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam longint LN2_Q30     = 64'sd744261118;
    localparam longint ONE_Q30     = 64'sd1073741824;

    localparam logic signed [Q_W-1:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 48'sh8000_0000_0000;

    // Input queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register map: one register, index taken from the word address bit.
    localparam int PADDR_W = 3;
    localparam logic REG_INV_RESOLUTION = 1'b0;
    localparam logic [31:0] INV_RES_RESET = 32'd65536;

    // Item actions.
    localparam logic ACT_BEGIN = 1'b0;

    typedef struct packed {
        logic               action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] frc_x;
        logic signed [31:0] frc_y;
        logic signed [31:0] frc_z;
        logic               last_in_node;
    } t_in_item;

    typedef struct packed {
        logic signed [Q_W-1:0] density;
        logic signed [Q_W-1:0] velocity_field;
        logic signed [Q_W-1:0] force_field;
    } t_out_item;

    // Classification of the queue head, handed from the front to the back.
    typedef struct packed {
        logic valid;
        logic is_atom;
        logic emit;
    } t_head_ctl;

    // Multiply operations of the back-end sequence.
    typedef enum logic [3:0] {
        OP_W, OP_T, OP_U, OP_VV, OP_A, OP_B, OP_UU, OP_C, OP_TT, OP_UV, OP_KV, OP_KS
    } t_op;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ISSUE = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_EXPY  = 6'b001000,
        ST_EXPK  = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    typedef logic [EXP_VAL_W-1:0] t_exp_tab [EXP_TABLE_DEPTH];

    // Shift-and-subtract quotient of two non-negative constants.
    function automatic longint cdiv(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            q = q <<< 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // Table of 2^(-i/depth) in Q16.16, built by a power series at elaboration.
    function automatic t_exp_tab build_exp_table();
        t_exp_tab tab;
        longint   z;
        longint   term;
        longint   sum;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            z    = (longint'(i) * LN2_Q30) >>> EXP_IDX_W;
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int k = 1; k <= 24; k++) begin
                term = cdiv((term * z) >>> 30, longint'(k));
                sum  = ((k & 1) == 1) ? sum - term : sum + term;
            end
            tab[i] = EXP_VAL_W'((sum + 64'sd8192) >>> 14);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TABLE = build_exp_table();

    function automatic logic signed [Q_W-1:0] sx32(input logic signed [31:0] v);
        return {{(Q_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1]) begin
            return s[Q_W] ? Q_MIN : Q_MAX;
        end
        return s[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} - {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1]) begin
            return s[Q_W] ? Q_MIN : Q_MAX;
        end
        return s[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] sat_dbl(input logic signed [Q_W-1:0] x);
        if (x[Q_W-1] != x[Q_W-2]) begin
            return x[Q_W-1] ? Q_MIN : Q_MAX;
        end
        return {x[Q_W-2:0], 1'b0};
    endfunction

endpackage

/* rtl/gfa_front.sv */
// Front end: accepts input transactions into a short queue and classifies the head.
// Depends on gfa_pkg for the item type, the head control struct and the queue depth.

module gfa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gfa_pkg::t_in_item   i_in_item,
    output gfa_pkg::t_in_item   o_head,
    output gfa_pkg::t_head_ctl  o_head_ctl,
    input  logic                i_pop
);

    gfa_pkg::t_in_item               r_q [gfa_pkg::QUEUE_DEPTH];
    logic [gfa_pkg::QPTR_W-1:0]      r_wptr;
    logic [gfa_pkg::QPTR_W-1:0]      r_rptr;
    logic [gfa_pkg::QCNT_W-1:0]      r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_in_ready = (r_count != gfa_pkg::QCNT_W'(gfa_pkg::QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && (r_count != '0);

    // Head of the queue and its classification.
    assign o_head             = r_q[r_rptr];
    assign o_head_ctl.valid   = (r_count != '0);
    assign o_head_ctl.is_atom = (r_q[r_rptr].action != gfa_pkg::ACT_BEGIN);
    assign o_head_ctl.emit    = r_q[r_rptr].last_in_node;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= i_in_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/gfa_qmul.sv */
// Multi-cycle Q16.16 multiplier: four 24x24 partial products, then saturation to 48 bits.
// Depends on gfa_pkg for the word width and saturation limits.

module gfa_qmul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [gfa_pkg::Q_W-1:0]    i_a,
    input  logic signed [gfa_pkg::Q_W-1:0]    i_b,
    output logic                              o_busy,
    output logic                              o_done,
    output logic signed [gfa_pkg::Q_W-1:0]    o_result
);

    logic [47:0]  r_ma;
    logic [47:0]  r_mb;
    logic         r_neg;
    logic [95:0]  r_acc;
    logic [2:0]   r_step;
    logic         r_busy;
    logic         r_done;
    logic signed [gfa_pkg::Q_W-1:0] r_result;

    logic [23:0]  w_pa;
    logic [23:0]  w_pb;
    logic [47:0]  w_pp;
    logic [95:0]  w_pp_sh;
    logic [79:0]  w_q;
    logic         w_over_pos;
    logic         w_over_neg;

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // Partial product for the current step.
    always_comb begin
        w_pa    = r_ma[23:0];
        w_pb    = r_mb[23:0];
        w_pp_sh = '0;
        unique case (r_step)
            3'd0: begin
                w_pa = r_ma[23:0];
                w_pb = r_mb[23:0];
            end
            3'd1: begin
                w_pa = r_ma[47:24];
                w_pb = r_mb[23:0];
            end
            3'd2: begin
                w_pa = r_ma[23:0];
                w_pb = r_mb[47:24];
            end
            3'd3: begin
                w_pa = r_ma[47:24];
                w_pb = r_mb[47:24];
            end
            default: begin
                w_pa = '0;
                w_pb = '0;
            end
        endcase
        w_pp = w_pa * w_pb;
        unique case (r_step)
            3'd0:         w_pp_sh = {48'b0, w_pp};
            3'd1, 3'd2:   w_pp_sh = {24'b0, w_pp, 24'b0};
            3'd3:         w_pp_sh = {w_pp, 48'b0};
            default:      w_pp_sh = '0;
        endcase
    end

    // Truncated magnitude and its overflow limits.
    assign w_q        = r_acc[95:16];
    assign w_over_pos = |w_q[79:47];
    assign w_over_neg = (|w_q[79:48]) || (w_q[47] && (|w_q[46:0]));

    // Operand capture, accumulation and final saturation step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[47] ? 48'(-i_a) : 48'(i_a);
            r_mb  <= i_b[47] ? 48'(-i_b) : 48'(i_b);
            r_neg <= i_a[47] ^ i_b[47];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step == 3'd4) begin
                if (r_neg) begin
                    r_result <= w_over_neg ? gfa_pkg::Q_MIN : -$signed(w_q[47:0]);
                end else begin
                    r_result <= w_over_pos ? gfa_pkg::Q_MAX : $signed(w_q[47:0]);
                end
            end else begin
                r_acc <= r_acc + w_pp_sh;
            end
        end
    end

endmodule

/* rtl/gfa_back.sv */
// Back end: sequences the kernel arithmetic of each item through the shared multiplier,
// keeps the node position and the three sums, and holds the result register.
// Depends on gfa_pkg and gfa_qmul.

module gfa_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gfa_pkg::t_in_item   i_head,
    input  gfa_pkg::t_head_ctl  i_head_ctl,
    output logic                o_pop,
    input  logic [31:0]         i_inv_res,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gfa_pkg::t_out_item  o_out_item
);

    typedef logic signed [gfa_pkg::Q_W-1:0] t_q;

    gfa_pkg::t_state            r_state;
    gfa_pkg::t_state            n_state;
    gfa_pkg::t_op               r_op;
    logic [gfa_pkg::DIM_W-1:0]  r_dim;
    gfa_pkg::t_in_item          r_item;
    logic signed [31:0]         r_node [gfa_pkg::DIMENSIONS];
    t_q                         r_dens;
    t_q                         r_vels;
    t_q                         r_frcs;
    t_q                         r_w;
    t_q                         r_t;
    t_q                         r_u;
    t_q                         r_vv;
    t_q                         r_ab;
    t_q                         r_uu;
    t_q                         r_c;
    t_q                         r_arg;
    t_q                         r_sv;
    t_q                         r_sf;
    t_q                         r_k;
    logic [gfa_pkg::Y_W-1:0]    r_y;
    logic                       r_kzero;
    logic                       r_out_valid;
    gfa_pkg::t_out_item         r_out;

    logic signed [31:0]         w_pos [3];
    logic signed [31:0]         w_vel [3];
    logic signed [31:0]         w_frc [3];
    t_q                         w_d;
    t_q                         w_v;
    t_q                         w_f;
    t_q                         w_ir;
    t_q                         w_opa;
    t_q                         w_opb;
    logic                       w_mul_start;
    logic                       w_mul_busy;
    logic                       w_mul_done;
    t_q                         w_mul_res;
    logic                       w_last_dim;
    logic                       w_out_free;
    logic [gfa_pkg::ARG_W-1:0]  w_arg_eff;
    logic [36:0]                w_yprod;
    logic [4:0]                 w_n;
    logic [gfa_pkg::EXP_IDX_W-1:0] w_idx;
    logic [47:0]                w_kshift;

    assign w_pos[0] = r_item.pos_x;
    assign w_pos[1] = r_item.pos_y;
    assign w_pos[2] = r_item.pos_z;
    assign w_vel[0] = r_item.vel_x;
    assign w_vel[1] = r_item.vel_y;
    assign w_vel[2] = r_item.vel_z;
    assign w_frc[0] = r_item.frc_x;
    assign w_frc[1] = r_item.frc_y;
    assign w_frc[2] = r_item.frc_z;

    // Per-dimension operands.
    assign w_d  = gfa_pkg::sx32(r_node[r_dim]) - gfa_pkg::sx32(w_pos[r_dim]);
    assign w_v  = gfa_pkg::sx32(w_vel[r_dim]);
    assign w_f  = gfa_pkg::sx32(w_frc[r_dim]);
    assign w_ir = {16'b0, i_inv_res};

    assign w_last_dim = (r_dim == gfa_pkg::DIM_W'(gfa_pkg::DIMENSIONS - 1));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_pop      = (r_state == gfa_pkg::ST_IDLE) && i_head_ctl.valid;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_op)
            gfa_pkg::OP_W:  begin w_opa = w_ir;  w_opb = w_ir;  end
            gfa_pkg::OP_T:  begin w_opa = w_d;   w_opb = w_ir;  end
            gfa_pkg::OP_U:  begin w_opa = w_d;   w_opb = r_w;   end
            gfa_pkg::OP_VV: begin w_opa = w_v;   w_opb = w_v;   end
            gfa_pkg::OP_A:  begin w_opa = r_u;   w_opb = w_f;   end
            gfa_pkg::OP_B:  begin w_opa = r_w;   w_opb = r_vv;  end
            gfa_pkg::OP_UU: begin w_opa = r_u;   w_opb = r_u;   end
            gfa_pkg::OP_C:  begin w_opa = r_vv;  w_opb = r_uu;  end
            gfa_pkg::OP_TT: begin w_opa = r_t;   w_opb = r_t;   end
            gfa_pkg::OP_UV: begin w_opa = r_u;   w_opb = w_v;   end
            gfa_pkg::OP_KV: begin w_opa = r_k;   w_opb = r_sv;  end
            gfa_pkg::OP_KS: begin w_opa = r_k;   w_opb = r_sf;  end
            default:        begin w_opa = '0;    w_opb = '0;    end
        endcase
    end

    assign w_mul_start = (r_state == gfa_pkg::ST_ISSUE);

    gfa_qmul u_qmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (w_opa),
        .i_b      (w_opb),
        .o_busy   (w_mul_busy),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    // Exponential: argument scaled by log2(e), then table lookup and shift.
    assign w_arg_eff = r_arg[gfa_pkg::Q_W-1] ? '0 : r_arg[gfa_pkg::ARG_W-1:0];
    assign w_yprod   = {17'b0, w_arg_eff} * {20'b0, gfa_pkg::LOG2E_Q16};
    assign w_n       = r_y[gfa_pkg::Y_W-1:16];
    assign w_idx     = r_y[15:16-gfa_pkg::EXP_IDX_W];
    assign w_kshift  = {31'b0, gfa_pkg::EXP_TABLE[w_idx]} >> w_n;

    // Sequencer state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gfa_pkg::ST_IDLE: begin
                if (i_head_ctl.valid) begin
                    if (i_head_ctl.is_atom) begin
                        n_state = gfa_pkg::ST_ISSUE;
                    end else if (i_head_ctl.emit) begin
                        n_state = gfa_pkg::ST_OUT;
                    end
                end
            end
            gfa_pkg::ST_ISSUE: n_state = gfa_pkg::ST_WAIT;
            gfa_pkg::ST_WAIT: begin
                if (w_mul_done) begin
                    if (r_op == gfa_pkg::OP_UV && w_last_dim) begin
                        n_state = gfa_pkg::ST_EXPY;
                    end else if (r_op == gfa_pkg::OP_KS) begin
                        n_state = r_item.last_in_node ? gfa_pkg::ST_OUT : gfa_pkg::ST_IDLE;
                    end else begin
                        n_state = gfa_pkg::ST_ISSUE;
                    end
                end
            end
            gfa_pkg::ST_EXPY: n_state = gfa_pkg::ST_EXPK;
            gfa_pkg::ST_EXPK: n_state = gfa_pkg::ST_ISSUE;
            gfa_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = gfa_pkg::ST_IDLE;
                end
            end
            default: n_state = gfa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gfa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Node position, sums and per-item temporaries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= gfa_pkg::OP_W;
            r_dim  <= '0;
            r_dens <= '0;
            r_vels <= '0;
            r_frcs <= '0;
            for (int k = 0; k < gfa_pkg::DIMENSIONS; k++) begin
                r_node[k] <= '0;
            end
        end else begin
            unique case (r_state)
                gfa_pkg::ST_IDLE: begin
                    if (i_head_ctl.valid) begin
                        r_item <= i_head;
                        if (i_head_ctl.is_atom) begin
                            r_op  <= gfa_pkg::OP_W;
                            r_dim <= '0;
                            r_arg <= '0;
                            r_sv  <= '0;
                            r_sf  <= '0;
                        end else begin
                            r_node[0] <= i_head.pos_x;
                            if (gfa_pkg::DIMENSIONS > 1) begin
                                r_node[gfa_pkg::DIMENSIONS > 1 ? 1 : 0] <= i_head.pos_y;
                            end
                            if (gfa_pkg::DIMENSIONS > 2) begin
                                r_node[gfa_pkg::DIMENSIONS > 2 ? 2 : 0] <= i_head.pos_z;
                            end
                            r_dens <= '0;
                            r_vels <= '0;
                            r_frcs <= '0;
                        end
                    end
                end
                gfa_pkg::ST_WAIT: begin
                    if (w_mul_done) begin
                        unique case (r_op)
                            gfa_pkg::OP_W:  begin r_w  <= w_mul_res; r_op <= gfa_pkg::OP_T;  end
                            gfa_pkg::OP_T:  begin r_t  <= w_mul_res; r_op <= gfa_pkg::OP_U;  end
                            gfa_pkg::OP_U:  begin r_u  <= w_mul_res; r_op <= gfa_pkg::OP_VV; end
                            gfa_pkg::OP_VV: begin r_vv <= w_mul_res; r_op <= gfa_pkg::OP_A;  end
                            gfa_pkg::OP_A:  begin r_ab <= w_mul_res; r_op <= gfa_pkg::OP_B;  end
                            gfa_pkg::OP_B: begin
                                r_ab <= gfa_pkg::sat_sub(r_ab, w_mul_res);
                                r_op <= gfa_pkg::OP_UU;
                            end
                            gfa_pkg::OP_UU: begin r_uu <= w_mul_res; r_op <= gfa_pkg::OP_C;  end
                            gfa_pkg::OP_C: begin
                                r_c  <= gfa_pkg::sat_dbl(w_mul_res);
                                r_op <= gfa_pkg::OP_TT;
                            end
                            gfa_pkg::OP_TT: begin
                                r_arg <= gfa_pkg::sat_add(r_arg, w_mul_res);
                                r_sf  <= gfa_pkg::sat_add(r_sf, gfa_pkg::sat_add(r_ab, r_c));
                                r_op  <= gfa_pkg::OP_UV;
                            end
                            gfa_pkg::OP_UV: begin
                                r_sv <= gfa_pkg::sat_add(r_sv, w_mul_res);
                                if (w_last_dim) begin
                                    r_op <= gfa_pkg::OP_KV;
                                end else begin
                                    r_dim <= r_dim + 1'b1;
                                    r_op  <= gfa_pkg::OP_T;
                                end
                            end
                            gfa_pkg::OP_KV: begin
                                r_vels <= gfa_pkg::sat_add(r_vels, gfa_pkg::sat_dbl(w_mul_res));
                                r_op   <= gfa_pkg::OP_KS;
                            end
                            gfa_pkg::OP_KS: begin
                                r_frcs <= gfa_pkg::sat_add(r_frcs, gfa_pkg::sat_dbl(w_mul_res));
                                r_op   <= gfa_pkg::OP_W;
                            end
                            default: r_op <= gfa_pkg::OP_W;
                        endcase
                    end
                end
                gfa_pkg::ST_EXPY: begin
                    r_y     <= w_yprod[36:16];
                    r_kzero <= !r_arg[gfa_pkg::Q_W-1] && (|r_arg[gfa_pkg::Q_W-2:gfa_pkg::ARG_W]);
                end
                gfa_pkg::ST_EXPK: begin
                    r_k    <= r_kzero ? '0 : $signed(w_kshift);
                    r_dens <= gfa_pkg::sat_add(r_dens, r_kzero ? '0 : $signed(w_kshift));
                end
                gfa_pkg::ST_ISSUE, gfa_pkg::ST_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: holds one finished transaction while the next item proceeds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == gfa_pkg::ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gfa_pkg::ST_OUT && w_out_free) begin
            r_out.density        <= r_dens;
            r_out.velocity_field <= r_vels;
            r_out.force_field    <= r_frcs;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_issue_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gfa_pkg::ST_ISSUE |=> r_state == gfa_pkg::ST_WAIT)
        else $error("issue cycle not followed by wait");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_state == gfa_pkg::ST_WAIT)
        else $error("multiplier finished outside wait state");
    a_start_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> !w_mul_busy)
        else $error("multiplier started while busy");
    a_dim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dim <= gfa_pkg::DIM_W'(gfa_pkg::DIMENSIONS - 1))
        else $error("dimension counter out of range");
`endif

endmodule

/* rtl/gaussian_field_accumulator.sv */
// Top level of the Gaussian field accumulator: configuration register and the
// front/back pair. Depends on gfa_pkg, gfa_front and gfa_back.
//
// Usage: a begin transaction on the input channel loads a grid node position and
// clears the density, velocity and force sums. Each atom transaction adds its
// Gaussian kernel contribution. A transaction with last_in_node set produces one
// output transaction carrying the three saturated sums after its own update.
// Input items wait in a two-entry queue; the back end takes one at a time.
// An atom is taken from the queue, then makes thirty Q16.16 products through one
// shared multiplier that forms a product from four 24x24 partial products, and
// evaluates the exponential in the states EXPY and EXPK. A begin item is handled
// in the idle state; either kind also passes the output state when it emits. The result
// sits in an output register; while the receiver stalls, the back end holds the
// next result and the queue keeps accepting until full. Reset clears the node
// position, the sums, the queue and the output valid, and sets inv_resolution to
// 1.0. The user is to write inv_resolution over the APB port at byte address 0
// only while the block is idle; the block itself does not enforce this.

module gaussian_field_accumulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  gfa_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output gfa_pkg::t_out_item                o_out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gfa_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [31:0]         r_inv_res;
    gfa_pkg::t_in_item   w_head;
    gfa_pkg::t_head_ctl  w_head_ctl;
    logic                w_pop;
    logic                w_sel_inv_res;

    // Configuration register.
    assign pready        = 1'b1;
    assign w_sel_inv_res = (paddr[gfa_pkg::PADDR_W-1] == gfa_pkg::REG_INV_RESOLUTION);
    assign prdata        = w_sel_inv_res ? r_inv_res : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_res <= gfa_pkg::INV_RES_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_inv_res) begin
            r_inv_res <= pwdata;
        end
    end

    gfa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_head     (w_head),
        .o_head_ctl (w_head_ctl),
        .i_pop      (w_pop)
    );

    gfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_head_ctl  (w_head_ctl),
        .o_pop       (w_pop),
        .i_inv_res   (r_inv_res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* test/gaussian_field_accumulator_test.sv */
// Self-checking testbench for the Gaussian field accumulator: a scoreboard class
// predicts the saturated Q16.16 sums per node and checks every output transaction.
// Depends on gfa_pkg and gaussian_field_accumulator.
`timescale 1ns / 1ps

class field_scoreboard;
    gfa_pkg::t_out_item expected_sums[$];
    longint node_pos[3];
    longint density_acc;
    longint velocity_acc;
    longint force_acc;
    logic [31:0] inv_res;
    longint pow2_tab[gfa_pkg::EXP_TABLE_DEPTH];
    int errors;

    function new();
        longint z;
        longint term;
        longint sum;
        // Table of 2^(-i/depth) in Q16.16 from an alternating power series.
        for (int i = 0; i < gfa_pkg::EXP_TABLE_DEPTH; i++) begin
            z = (longint'(i) * 744261118) / gfa_pkg::EXP_TABLE_DEPTH;
            term = 64'sd1 << 30;
            sum = term;
            for (int k = 1; k <= 24; k++) begin
                term = ((term * z) >>> 30) / k;
                sum = (k % 2 == 1) ? sum - term : sum + term;
            end
            pow2_tab[i] = (sum + 8192) >>> 14;
        end
        errors = 0;
        reset_state();
    endfunction

    function void reset_state();
        for (int k = 0; k < 3; k++) node_pos[k] = 0;
        density_acc = 0;
        velocity_acc = 0;
        force_acc = 0;
        inv_res = 32'd65536;
        expected_sums.delete();
    endfunction

    function void write_reg(int index, logic [31:0] value);
        if (index == 0) inv_res = value;
    endfunction

    function longint clamp(longint x);
        if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return x;
    endfunction

    // Q16.16 product, magnitude truncated, then saturated to 48 bits.
    function longint fx_mul(longint a, longint b);
        logic [47:0] ma;
        logic [47:0] mb;
        logic [95:0] prod;
        logic [95:0] r;
        bit neg;
        ma = (a < 0) ? 48'(-a) : 48'(a);
        mb = (b < 0) ? 48'(-b) : 48'(b);
        neg = (a < 0) != (b < 0);
        prod = 96'(ma) * 96'(mb);
        r = prod >> 16;
        if (r >= 96'h8000_0000_0000) return neg ? -64'sh8000_0000_0000 : 64'sh7FFF_FFFF_FFFF;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function longint kernel_value(longint arg);
        longint y;
        longint n;
        longint idx;
        if (arg < 0) arg = 0;
        if (arg >= (64'sd16 << 16)) return 0;
        y = (arg * 94548) >>> 16;
        n = y >>> 16;
        idx = ((y & 64'hFFFF) * gfa_pkg::EXP_TABLE_DEPTH) >>> 16;
        if (n > 31) return 0;
        return pow2_tab[idx] >>> n;
    endfunction

    function void note_input(gfa_pkg::t_in_item it);
        longint pos[3];
        longint vel[3];
        longint frc[3];
        longint ir, w, arg, sv, sf, kv, d, t, u, vv, a, b, c;
        gfa_pkg::t_out_item e;
        pos[0] = longint'(it.pos_x); pos[1] = longint'(it.pos_y); pos[2] = longint'(it.pos_z);
        vel[0] = longint'(it.vel_x); vel[1] = longint'(it.vel_y); vel[2] = longint'(it.vel_z);
        frc[0] = longint'(it.frc_x); frc[1] = longint'(it.frc_y); frc[2] = longint'(it.frc_z);
        if (it.action == gfa_pkg::ACT_BEGIN) begin
            for (int k = 0; k < 3; k++) node_pos[k] = pos[k];
            density_acc = 0;
            velocity_acc = 0;
            force_acc = 0;
        end else begin
            ir = longint'(inv_res);
            w = fx_mul(ir, ir);
            arg = 0;
            sv = 0;
            sf = 0;
            for (int k = 0; k < gfa_pkg::DIMENSIONS; k++) begin
                d = node_pos[k] - pos[k];
                t = fx_mul(d, ir);
                u = fx_mul(d, w);
                vv = fx_mul(vel[k], vel[k]);
                a = fx_mul(u, frc[k]);
                b = fx_mul(w, vv);
                c = clamp(2 * fx_mul(vv, fx_mul(u, u)));
                arg = clamp(arg + fx_mul(t, t));
                sv = clamp(sv + fx_mul(u, vel[k]));
                sf = clamp(sf + clamp(clamp(a - b) + c));
            end
            kv = kernel_value(arg);
            density_acc = clamp(density_acc + kv);
            velocity_acc = clamp(velocity_acc + clamp(2 * fx_mul(kv, sv)));
            force_acc = clamp(force_acc + clamp(2 * fx_mul(kv, sf)));
        end
        if (it.last_in_node) begin
            e.density = density_acc[47:0];
            e.velocity_field = velocity_acc[47:0];
            e.force_field = force_acc[47:0];
            expected_sums.push_back(e);
        end
    endfunction

    function void check_result(gfa_pkg::t_out_item got);
        gfa_pkg::t_out_item e;
        if (expected_sums.size() == 0) begin
            $display("%0t: unexpected output transaction %h", $time, got);
            errors++;
            return;
        end
        e = expected_sums.pop_front();
        if (got.density !== e.density) begin
            $display("%0t: density expected %h actual %h", $time, e.density, got.density);
            errors++;
        end
        if (got.velocity_field !== e.velocity_field) begin
            $display("%0t: velocity_field expected %h actual %h", $time,
                     e.velocity_field, got.velocity_field);
            errors++;
        end
        if (got.force_field !== e.force_field) begin
            $display("%0t: force_field expected %h actual %h", $time,
                     e.force_field, got.force_field);
            errors++;
        end
    endfunction

    function int pending();
        return expected_sums.size();
    endfunction
endclass

module gaussian_field_accumulator_test;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 700;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    gfa_pkg::t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_ready;
    gfa_pkg::t_out_item o_out_item;
    logic psel;
    logic penable;
    logic pwrite;
    logic [gfa_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    field_scoreboard sums_board;
    int burst_left;
    int items_sent;
    int idle_cycles;
    bit hold_request;

    gaussian_field_accumulator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Monitor: note accepted inputs and check accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sums_board.note_input(i_in_item);
            if (o_out_valid && i_out_ready) sums_board.check_result(o_out_item);
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL gaussian_field_accumulator");
            $finish;
        end
    end

    // Receiver: stretches of steady, random and mostly stalled ready, plus a long hold.
    initial begin
        int mode;
        int span;
        i_out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 300);
            repeat (span) begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'd0;
            default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 3))
            0: return 32'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
            1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            2: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return $urandom();
        endcase
    endfunction

    function automatic gfa_pkg::t_in_item make_item(logic act, logic last);
        gfa_pkg::t_in_item it;
        it.action = act;
        it.pos_x = pick_value(); it.pos_y = pick_value(); it.pos_z = pick_value();
        it.vel_x = pick_value(); it.vel_y = pick_value(); it.vel_z = pick_value();
        it.frc_x = pick_value(); it.frc_y = pick_value(); it.frc_z = pick_value();
        it.last_in_node = last;
        return it;
    endfunction

    // Offer one item and hold it until the transaction completes, then maybe pause.
    task automatic offer(gfa_pkg::t_in_item it);
        i_in_item <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 10);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sums_board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [gfa_pkg::PADDR_W-1:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sums_board.write_reg(addr >> 2, value);
    endtask

    // Node sequences: a begin, atoms placed around the node, the last one emitting; now and then a lone random item.
    task automatic run_nodes(int count);
        gfa_pkg::t_in_item it;
        gfa_pkg::t_in_item node;
        int atoms;
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                offer(make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end else begin
                node = make_item(gfa_pkg::ACT_BEGIN, $urandom_range(0, 15) == 0);
                offer(node);
                atoms = $urandom_range(1, 6);
                for (int j = 0; j < atoms; j++) begin
                    it = make_item(1'b1, j == atoms - 1 || $urandom_range(0, 7) == 0);
                    it.pos_x = node.pos_x - pick_offset();
                    it.pos_y = node.pos_y - pick_offset();
                    it.pos_z = node.pos_z - pick_offset();
                    offer(it);
                end
            end
        end
    endtask

    initial begin
        gfa_pkg::t_in_item it;
        sums_board = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 4;
        items_sent = 0;
        idle_cycles = 0;
        hold_request = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // An atom before any begin works on the reset node and sums.
        it = '0;
        it.action = 1'b1;
        it.last_in_node = 1'b1;
        offer(it);
        // Begin at the extremes of position, emitting zeros.
        it = make_item(gfa_pkg::ACT_BEGIN, 1'b1);
        it.pos_x = 32'h8000_0000; it.pos_y = 32'h7FFF_FFFF; it.pos_z = 32'h8000_0000;
        offer(it);
        // A far atom whose kernel vanishes.
        it = make_item(1'b1, 1'b1);
        it.pos_x = 32'h7FFF_FFFF; it.pos_y = 32'h8000_0000; it.pos_z = 32'h7FFF_FFFF;
        offer(it);
        // Near atoms with extreme velocity and force, sums kept across emissions.
        it = make_item(gfa_pkg::ACT_BEGIN, 1'b0);
        it.pos_x = 32'h0001_0000; it.pos_y = 32'hFFFF_0000; it.pos_z = 32'd0;
        offer(it);
        it = make_item(1'b1, 1'b1);
        it.pos_x = 32'h0001_8000; it.pos_y = 32'hFFFF_4000; it.pos_z = 32'h0000_2000;
        it.vel_x = 32'h7FFF_FFFF; it.vel_y = 32'h8000_0000; it.vel_z = 32'h7FFF_FFFF;
        it.frc_x = 32'h8000_0000; it.frc_y = 32'h7FFF_FFFF; it.frc_z = 32'h8000_0000;
        offer(it);
        it.last_in_node = 1'b1;
        offer(it);
        it = make_item(1'b1, 1'b1);
        it.pos_x = 32'h0001_0000; it.pos_y = 32'hFFFF_0000; it.pos_z = 32'd0;
        offer(it);
        drain();
        // A write to an unmapped word changes nothing.
        reg_write(3'd4, 32'h0000_0001);
        run_nodes(40);
        drain();

        // Settings of the kernel width, extremes among them.
        reg_write(3'd0, 32'd1);
        hold_request = 1'b1;
        run_nodes(260);
        drain();
        reg_write(3'd0, 32'hFFFF_FFFF);
        run_nodes(260);
        drain();
        reg_write(3'd0, 32'd0);
        run_nodes(200);
        drain();
        reg_write(3'd0, $urandom_range(8192, 524288));
        run_nodes(300);
        drain();
        reg_write(3'd0, 32'd65536);
        run_nodes(300);
        drain();
        reg_write(3'd0, $urandom());
        run_nodes(240);
        drain();

        if (sums_board.errors == 0) begin
            $display("PASS gaussian_field_accumulator");
        end else begin
            $display("FAIL gaussian_field_accumulator");
        end
        $finish;
    end
endmodule
